/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks on clk, with and without the reset qualifier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RVSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RVSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVSC_ASSERT(lbl, prop, msg)
`define RVSC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/rvsc_pkg.sv */
// ----------------------------------------------------------------------------
// rvsc_pkg
// shared constants, opcodes and stage types of the rv32 subset core
// ----------------------------------------------------------------------------
`default_nettype none

package rvsc_pkg;

  localparam int IMEM_DEPTH = 4096;
  localparam int DMEM_DEPTH = 1024;
  localparam int XLEN       = 32;
  localparam int NREG       = 32;
  localparam int RIDX_W     = $clog2(NREG);
  localparam int PC_W       = $clog2(IMEM_DEPTH);
  localparam int PLEN_W     = PC_W + 1;
  localparam int DADDR_W    = $clog2(DMEM_DEPTH);
  localparam int CLR_DEPTH  = (DMEM_DEPTH > NREG) ? DMEM_DEPTH : NREG;
  localparam int CNT_W      = $clog2(CLR_DEPTH) + 1;

  localparam logic [XLEN-1:0] BYTE_MASK = 32'h0000_00FF;

  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SRA  = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_BYTE = 3'b000;

  localparam logic [RIDX_W-1:0] REG_A0 = 5'd10;
  localparam logic [RIDX_W-1:0] REG_A1 = 5'd11;

  typedef enum logic [6:0] {
    OPC_OP     = 7'b0110011,
    OPC_OPIMM  = 7'b0010011,
    OPC_LOAD   = 7'b0000011,
    OPC_STORE  = 7'b0100011,
    OPC_BRANCH = 7'b1100011,
    OPC_JAL    = 7'b1101111,
    OPC_LUI    = 7'b0110111
  } opcode_t;

  typedef struct packed {
    logic               stopped;
    logic [PC_W-1:0]    next_pc;
    logic               rf_we;
    logic [RIDX_W-1:0]  rd;
    logic [XLEN-1:0]    wval;
    logic               is_load;
    logic               byte_ld;
    logic               dm_we;
    logic [DADDR_W-1:0] dm_addr;
    logic [XLEN-1:0]    dm_wdata;
  } ex_res_t;

endpackage

`default_nettype wire

/* sv/rvsc_ram.sv */
// ----------------------------------------------------------------------------
// rvsc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rvsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      data_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= data_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* sv/rvsc_exec.sv */
// ----------------------------------------------------------------------------
// rvsc_exec
// decode, immediates, alu, branch and halt logic for one instruction word
// ----------------------------------------------------------------------------
`default_nettype none

module rvsc_exec import rvsc_pkg::*; (
  input  logic [XLEN-1:0]   ins,
  input  logic [XLEN-1:0]   opa,
  input  logic [XLEN-1:0]   opb,
  input  logic [PC_W-1:0]   pc,
  input  logic              halted,
  input  logic [PLEN_W-1:0] plen,
  output ex_res_t           res
);

  logic [RIDX_W-1:0] rd;
  logic [2:0]        f3;
  logic [XLEN-1:0]   imm_i;
  logic [XLEN-1:0]   imm_s;
  logic [XLEN-1:0]   imm_b;
  logic [XLEN-1:0]   imm_j;
  logic [XLEN-1:0]   imm_u;
  logic [XLEN-1:0]   eff_ld;
  logic [XLEN-1:0]   eff_st;
  logic [XLEN-1:0]   link;
  logic [XLEN-1:0]   off_src;
  logic [XLEN-1:0]   off_rnd;
  logic [XLEN-1:0]   off_q;
  logic [PC_W-1:0]   npc;
  logic              wr;
  logic [XLEN-1:0]   wv;
  logic              taken;

  function automatic logic [XLEN-1:0] alu_op(input logic [2:0] fn,
                                              input logic [XLEN-1:0] x,
                                              input logic [XLEN-1:0] y);
    logic [XLEN-1:0] r;
    case (fn)
      F3_ADD:  r = x + y;
      F3_XOR:  r = x ^ y;
      F3_OR:   r = x | y;
      F3_SRA:  r = XLEN'($signed(x) >>> y[4:0]);
      default: r = y;
    endcase
    return r;
  endfunction

  assign rd     = ins[11:7];
  assign f3     = ins[14:12];
  assign imm_i  = (f3 == F3_SRA) ? {27'b0, ins[24:20]} : {{20{ins[31]}}, ins[31:20]};
  assign imm_s  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u  = {ins[31:12], 12'b0};
  assign eff_ld = opa + imm_i;
  assign eff_st = opa + imm_s;
  assign link   = {{(XLEN-PC_W-2){1'b0}}, pc, 2'b00} + XLEN'(4);

  always_comb begin
    res     = '0;
    wr      = 1'b0;
    wv      = '0;
    taken   = 1'b0;
    off_src = '0;
    case (opcode_t'(ins[6:0]))
      OPC_OP: begin
        wr = 1'b1;
        wv = alu_op(f3, opa, opb);
      end
      OPC_OPIMM: begin
        wr = 1'b1;
        wv = alu_op(f3, opa, imm_i);
      end
      OPC_LUI: begin
        wr = 1'b1;
        wv = imm_u;
      end
      OPC_LOAD: begin
        wr          = 1'b1;
        res.is_load = 1'b1;
        res.byte_ld = (f3 == F3_BYTE);
        res.dm_addr = eff_ld[DADDR_W-1:0];
      end
      OPC_STORE: begin
        res.dm_we    = 1'b1;
        res.dm_addr  = eff_st[DADDR_W-1:0];
        res.dm_wdata = (f3 == F3_BYTE) ? (opb & BYTE_MASK) : opb;
      end
      OPC_BRANCH: begin
        taken   = (opa == opb);
        off_src = imm_b;
      end
      OPC_JAL: begin
        wr      = 1'b1;
        wv      = link;
        taken   = 1'b1;
        off_src = imm_j;
      end
      default: begin
        wr = 1'b0;
      end
    endcase

    // divide by four rounding toward zero
    off_rnd = off_src + {{(XLEN-2){1'b0}}, {2{off_src[XLEN-1]}}};
    off_q   = XLEN'($signed(off_rnd) >>> 2);
    npc     = taken ? (pc + off_q[PC_W-1:0]) : (pc + PC_W'(1));

    res.rf_we   = wr && (rd != '0);
    res.rd      = res.rf_we ? rd : '0;
    res.wval    = (res.rf_we && !res.is_load) ? wv : '0;
    res.next_pc = npc;
    res.stopped = ({1'b0, npc} > plen);

    if (halted || (ins == '0)) begin
      res         = '0;
      res.stopped = 1'b1;
      res.next_pc = pc;
    end
  end

endmodule

`default_nettype wire

/* sv/rv32_subset_single_cycle_core.sv */
// an accepted instruction word passes the execute, memory and result registers before out_valid shows it
// throughput: one word per cycle while out_stall is low, bypassing from the two words ahead of it
// register and data reads go through rams with registered read ports
// synchronous active-low reset, then a clearing pass over max(DMEM_DEPTH, 32)
// addresses (1024) that zeroes data memory and registers; in_stall stays high
// cfg writes are taken at any time, also during the clearing pass
// ----------------------------------------------------------------------------
// rv32_subset_single_cycle_core
// rv32 subset core: execute stage, data memory stage and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rv32_subset_single_cycle_core import rvsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [XLEN-1:0]          in_instruction_word,
  input  logic                     cfg_write_enable,
  input  logic [PLEN_W-1:0]        cfg_write_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_stopped,
  output logic [PC_W-1:0]          out_next_pc,
  output logic                     out_reg_write_enable,
  output logic [RIDX_W-1:0]        out_reg_write_index,
  output logic signed [XLEN-1:0]   out_reg_write_value,
  output logic                     out_mem_write_enable,
  output logic [DADDR_W-1:0]       out_mem_address,
  output logic signed [XLEN-1:0]   out_mem_write_value,
  output logic signed [XLEN-1:0]   out_a0_value,
  output logic signed [XLEN-1:0]   out_a1_value
);

  logic               clearing_r;
  logic [CNT_W-1:0]   clr_cnt_r;
  logic [PLEN_W-1:0]  plen_r;
  logic               ex_v_r, ex_v_nxt;
  logic [XLEN-1:0]    ins_r;
  logic [PC_W-1:0]    pc_r;
  logic               halted_r;
  logic               mem_v_r, mem_v_nxt;
  ex_res_t            mem_r;
  logic               lw_v_r;
  logic [RIDX_W-1:0]  lw_idx_r;
  logic [XLEN-1:0]    lw_val_r;
  logic [XLEN-1:0]    a0_r, a0_nxt;
  logic [XLEN-1:0]    a1_r, a1_nxt;
  logic               out_v_r, out_v_nxt;
  logic               out_stopped_r;
  logic [PC_W-1:0]    out_pc_r;
  logic               out_rwe_r;
  logic [RIDX_W-1:0]  out_ridx_r;
  logic [XLEN-1:0]    out_rval_r;
  logic               out_mwe_r;
  logic [DADDR_W-1:0] out_maddr_r;
  logic [XLEN-1:0]    out_mval_r;
  logic [XLEN-1:0]    out_a0_r;
  logic [XLEN-1:0]    out_a1_r;

  logic               in_accept;
  logic               out_move;
  logic               mem_move;
  logic               mem_free;
  logic               ex_move;
  logic               ex_free;
  logic               commit_we;
  logic [XLEN-1:0]    rf_rdata_a;
  logic [XLEN-1:0]    rf_rdata_b;
  logic [XLEN-1:0]    dm_rdata;
  logic [XLEN-1:0]    mem_wval;
  logic [XLEN-1:0]    opa;
  logic [XLEN-1:0]    opb;
  ex_res_t            ex_res;
  logic               rf_we;
  logic [RIDX_W-1:0]  rf_waddr;
  logic [XLEN-1:0]    rf_wdata;
  logic               dm_we;
  logic [DADDR_W-1:0] dm_waddr;
  logic [XLEN-1:0]    dm_wdata;

  // handshake and stage flow
  assign out_move  = !out_v_r || !out_stall;
  assign mem_move  = mem_v_r && out_move;
  assign mem_free  = !mem_v_r || out_move;
  assign ex_move   = ex_v_r && mem_free;
  assign ex_free   = !ex_v_r || mem_free;
  assign in_stall  = !rst_n || clearing_r || !ex_free;
  assign in_accept = in_valid && !in_stall;

  assign ex_v_nxt  = in_accept || (ex_v_r && !mem_free);
  assign mem_v_nxt = ex_move || (mem_v_r && !out_move);
  assign out_v_nxt = mem_move || (out_v_r && out_stall);

  // writeback value of the word in the memory stage
  assign mem_wval  = mem_r.is_load ?
                     (mem_r.byte_ld ? (dm_rdata & BYTE_MASK) : dm_rdata) : mem_r.wval;
  assign commit_we = mem_move && mem_r.rf_we;

  // operand bypass: memory stage first, then the last committed write
  always_comb begin
    if (mem_v_r && mem_r.rf_we && (mem_r.rd == ins_r[19:15])) begin
      opa = mem_wval;
    end else if (lw_v_r && (lw_idx_r == ins_r[19:15])) begin
      opa = lw_val_r;
    end else begin
      opa = rf_rdata_a;
    end
    if (mem_v_r && mem_r.rf_we && (mem_r.rd == ins_r[24:20])) begin
      opb = mem_wval;
    end else if (lw_v_r && (lw_idx_r == ins_r[24:20])) begin
      opb = lw_val_r;
    end else begin
      opb = rf_rdata_b;
    end
  end

  rvsc_exec u_exec (
    .ins    (ins_r),
    .opa    (opa),
    .opb    (opb),
    .pc     (pc_r),
    .halted (halted_r),
    .plen   (plen_r),
    .res    (ex_res)
  );

  // ram write ports, shared with the clearing pass
  assign rf_we    = clearing_r ? (clr_cnt_r < CNT_W'(NREG)) : commit_we;
  assign rf_waddr = clearing_r ? clr_cnt_r[RIDX_W-1:0] : mem_r.rd;
  assign rf_wdata = clearing_r ? '0 : mem_wval;
  assign dm_we    = clearing_r ? (clr_cnt_r < CNT_W'(DMEM_DEPTH)) : (ex_move && ex_res.dm_we);
  assign dm_waddr = clearing_r ? clr_cnt_r[DADDR_W-1:0] : ex_res.dm_addr;
  assign dm_wdata = clearing_r ? '0 : ex_res.dm_wdata;

  rvsc_ram #(.WIDTH(XLEN), .DEPTH(NREG)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_accept),
    .raddr (in_instruction_word[19:15]),
    .rdata (rf_rdata_a)
  );

  rvsc_ram #(.WIDTH(XLEN), .DEPTH(NREG)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_accept),
    .raddr (in_instruction_word[24:20]),
    .rdata (rf_rdata_b)
  );

  rvsc_ram #(.WIDTH(XLEN), .DEPTH(DMEM_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (ex_move),
    .raddr (ex_res.dm_addr),
    .rdata (dm_rdata)
  );

  assign a0_nxt = (commit_we && (mem_r.rd == REG_A0)) ? mem_wval : a0_r;
  assign a1_nxt = (commit_we && (mem_r.rd == REG_A1)) ? mem_wval : a1_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      plen_r     <= '0;
      ex_v_r     <= 1'b0;
      mem_v_r    <= 1'b0;
      out_v_r    <= 1'b0;
      pc_r       <= '0;
      halted_r   <= 1'b0;
      lw_v_r     <= 1'b0;
      a0_r       <= '0;
      a1_r       <= '0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + CNT_W'(1);
        if (clr_cnt_r == CNT_W'(CLR_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (cfg_write_enable) begin
        plen_r <= cfg_write_data;
      end
      ex_v_r  <= ex_v_nxt;
      mem_v_r <= mem_v_nxt;
      out_v_r <= out_v_nxt;
      if (ex_move) begin
        pc_r     <= ex_res.next_pc;
        halted_r <= ex_res.stopped;
      end
      if (commit_we) begin
        lw_v_r <= 1'b1;
      end
      a0_r <= a0_nxt;
      a1_r <= a1_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ins_r <= in_instruction_word;
    end
    if (ex_move) begin
      mem_r <= ex_res;
    end
    if (commit_we) begin
      lw_idx_r <= mem_r.rd;
      lw_val_r <= mem_wval;
    end
    if (mem_move) begin
      out_stopped_r <= mem_r.stopped;
      out_pc_r      <= mem_r.next_pc;
      out_rwe_r     <= mem_r.rf_we;
      out_ridx_r    <= mem_r.rd;
      out_rval_r    <= mem_r.rf_we ? mem_wval : '0;
      out_mwe_r     <= mem_r.dm_we;
      out_maddr_r   <= mem_r.dm_addr;
      out_mval_r    <= mem_r.dm_wdata;
      out_a0_r      <= a0_nxt;
      out_a1_r      <= a1_nxt;
    end
  end

  assign out_valid            = out_v_r;
  assign out_stopped          = out_stopped_r;
  assign out_next_pc          = out_pc_r;
  assign out_reg_write_enable = out_rwe_r;
  assign out_reg_write_index  = out_ridx_r;
  assign out_reg_write_value  = out_rval_r;
  assign out_mem_write_enable = out_mwe_r;
  assign out_mem_address      = out_maddr_r;
  assign out_mem_write_value  = out_mval_r;
  assign out_a0_value         = out_a0_r;
  assign out_a1_value         = out_a1_r;

  `RVSC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> clearing_r && !out_v_r, "reset did not start clear")
  `RVSC_ASSERT(a_clear_idle, clearing_r |-> !ex_v_r && !mem_v_r, "word in flight during clear")
  `RVSC_ASSERT(a_halt_sticky, halted_r |=> halted_r && $stable(pc_r), "halted core moved")
  `RVSC_ASSERT(a_no_x0_write, mem_v_r && mem_r.rf_we |-> mem_r.rd != '0, "write to x0 pending")
  `RVSC_ASSERT(a_out_source, $rose(out_v_r) |-> $past(mem_v_r), "result without memory stage")

endmodule

`default_nettype wire

/* dv/rv32_subset_single_cycle_core_tb.sv */
// ----------------------------------------------------------------------------
// rv32_subset_single_cycle_core_tb
// directed table then random phases checked against an in-bench core model,
// bursty input, random result stalls and one long result hold-off
// ----------------------------------------------------------------------------
module rv32_subset_single_cycle_core_tb import rvsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1200;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic               stopped;
    logic [PC_W-1:0]    next_pc;
    logic               reg_we;
    logic [RIDX_W-1:0]  reg_idx;
    logic [XLEN-1:0]    reg_val;
    logic               mem_we;
    logic [DADDR_W-1:0] mem_addr;
    logic [XLEN-1:0]    mem_val;
    logic [XLEN-1:0]    a0;
    logic [XLEN-1:0]    a1;
  } retire_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] value;
    bit          pinned;
    retire_t     res;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [XLEN-1:0]          in_instruction_word = '0;
  logic                     cfg_write_enable = 1'b0;
  logic [PLEN_W-1:0]        cfg_write_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_stopped;
  logic [PC_W-1:0]          out_next_pc;
  logic                     out_reg_write_enable;
  logic [RIDX_W-1:0]        out_reg_write_index;
  logic signed [XLEN-1:0]   out_reg_write_value;
  logic                     out_mem_write_enable;
  logic [DADDR_W-1:0]       out_mem_address;
  logic signed [XLEN-1:0]   out_mem_write_value;
  logic signed [XLEN-1:0]   out_a0_value;
  logic signed [XLEN-1:0]   out_a1_value;

  logic [XLEN-1:0]   arch_regs [NREG];
  logic [XLEN-1:0]   data_words [DMEM_DEPTH];
  logic [PC_W-1:0]   fetch_pc = '0;
  logic              core_halted = 1'b0;
  logic [PLEN_W-1:0] prog_len = '0;

  retire_t  pending_retires [$];
  dir_row_t dir_rows [$];
  bit       word_pinned = 1'b0;
  retire_t  word_expect = '0;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       burst_left = 0;
  bit       no_gaps = 1'b0;
  int       hold_asked = 0;
  int       hold_given = 0;

  rv32_subset_single_cycle_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_instruction_word  (in_instruction_word),
    .cfg_write_enable     (cfg_write_enable),
    .cfg_write_data       (cfg_write_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_stopped          (out_stopped),
    .out_next_pc          (out_next_pc),
    .out_reg_write_enable (out_reg_write_enable),
    .out_reg_write_index  (out_reg_write_index),
    .out_reg_write_value  (out_reg_write_value),
    .out_mem_write_enable (out_mem_write_enable),
    .out_mem_address      (out_mem_address),
    .out_mem_write_value  (out_mem_write_value),
    .out_a0_value         (out_a0_value),
    .out_a1_value         (out_a1_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // instruction encoders
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [11:0] imm,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd);
    return {imm, rd, OPC_LUI};
  endfunction

  // core model
  function automatic logic [31:0] alu_result(input logic [2:0] f3, input logic [31:0] a,
                                             input logic [31:0] b);
    case (f3)
      F3_ADD: return a + b;
      F3_XOR: return a ^ b;
      F3_OR:  return a | b;
      F3_SRA: return 32'($signed(a) >>> b[4:0]);
      default: return b;
    endcase
  endfunction

  function automatic retire_t retire_word(input logic [31:0] w);
    retire_t         r;
    logic [6:0]      opc;
    logic [4:0]      rd, rs1, rs2;
    logic [2:0]      f3;
    logic [31:0]     a, b, imm, wval, addr, val;
    logic            wr, taken;
    int              off;
    logic [PC_W-1:0] npc;
    r = '0;
    wr = 1'b0;
    taken = 1'b0;
    wval = '0;
    off = 0;
    opc = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    rs1 = w[19:15];
    rs2 = w[24:20];
    if (!core_halted && w == 32'h0) core_halted = 1'b1;
    if (core_halted) begin
      r.stopped = 1'b1;
      r.next_pc = fetch_pc;
      r.a0 = arch_regs[REG_A0];
      r.a1 = arch_regs[REG_A1];
      return r;
    end
    a = arch_regs[rs1];
    b = arch_regs[rs2];
    case (opc)
      OPC_OPIMM, OPC_LOAD: begin
        imm = (f3 == F3_SRA) ? {27'b0, w[24:20]} : {{20{w[31]}}, w[31:20]};
      end
      OPC_STORE:  imm = {{20{w[31]}}, w[31:25], w[11:7]};
      OPC_BRANCH: imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      OPC_JAL:    imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      OPC_LUI:    imm = {w[31:12], 12'b0};
      default:    imm = '0;
    endcase
    case (opc)
      OPC_OP: begin
        wr = 1'b1;
        wval = alu_result(f3, a, b);
      end
      OPC_OPIMM: begin
        wr = 1'b1;
        wval = alu_result(f3, a, imm);
      end
      OPC_LUI: begin
        wr = 1'b1;
        wval = imm;
      end
      OPC_LOAD: begin
        addr = a + imm;
        val = data_words[addr[DADDR_W-1:0]];
        if (f3 == F3_BYTE) val = val & BYTE_MASK;
        wr = 1'b1;
        wval = val;
        r.mem_addr = addr[DADDR_W-1:0];
      end
      OPC_STORE: begin
        addr = a + imm;
        val = (f3 == F3_BYTE) ? (b & BYTE_MASK) : b;
        data_words[addr[DADDR_W-1:0]] = val;
        r.mem_we = 1'b1;
        r.mem_addr = addr[DADDR_W-1:0];
        r.mem_val = val;
      end
      OPC_BRANCH: begin
        if (a == b) begin
          taken = 1'b1;
          off = $signed(imm) / 4;
        end
      end
      OPC_JAL: begin
        wr = 1'b1;
        wval = 32'(fetch_pc) * 4 + 4;
        taken = 1'b1;
        off = $signed(imm) / 4;
      end
      default: ;
    endcase
    if (wr && rd != 5'd0) begin
      arch_regs[rd] = wval;
      r.reg_we = 1'b1;
      r.reg_idx = rd;
      r.reg_val = wval;
    end
    npc = taken ? PC_W'(int'(fetch_pc) + off) : fetch_pc + 1'b1;
    fetch_pc = npc;
    if ({1'b0, npc} > prog_len) core_halted = 1'b1;
    r.stopped = core_halted;
    r.next_pc = npc;
    r.a0 = arch_regs[REG_A0];
    r.a1 = arch_regs[REG_A1];
    return r;
  endfunction

  // random word generation
  function automatic logic [4:0] pick_reg();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd2;
      3: return REG_A0;
      4: return REG_A1;
      default: return 5'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_f3();
    case ($urandom_range(0, 4))
      0: return F3_ADD;
      1: return F3_XOR;
      2: return F3_OR;
      3: return F3_SRA;
      default: return 3'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_imm12();
    case ($urandom_range(0, 7))
      0: return 12'h800;
      1: return 12'h7FF;
      2: return 12'hFFF;
      3: return 12'h000;
      4, 5: return 12'(int'($urandom_range(0, 31)) - 16);
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] make_word(input bit straight);
    logic [31:0] w;
    logic [2:0]  mf3;
    logic [4:0]  base;
    int          kind;
    kind = $urandom_range(0, 99);
    mf3 = ($urandom_range(0, 1) == 0) ? F3_BYTE : 3'($urandom);
    base = ($urandom_range(0, 1) == 0) ? 5'd0 : pick_reg();
    if (kind < 15) begin
      w = enc_r(7'($urandom), pick_reg(), pick_reg(), pick_f3(), pick_reg());
    end else if (kind < 35) begin
      w = enc_i(OPC_OPIMM, pick_imm12(), pick_reg(), pick_f3(), pick_reg());
    end else if (kind < 43) begin
      w = enc_u(20'($urandom), pick_reg());
    end else if (kind < 56) begin
      w = enc_i(OPC_LOAD, pick_imm12(), base, mf3, pick_reg());
    end else if (kind < 71) begin
      w = enc_s(pick_imm12(), pick_reg(), base, mf3);
    end else if (kind < 81) begin
      w = enc_b(($urandom_range(0, 1) == 0) ? 13'(2 * (int'($urandom_range(0, 32)) - 16))
                                            : {12'($urandom), 1'b0},
                pick_reg(), pick_reg(), ($urandom_range(0, 1) == 0) ? F3_ADD : 3'($urandom));
    end else if (kind < 89) begin
      w = enc_j(($urandom_range(0, 1) == 0) ? 21'(2 * (int'($urandom_range(0, 32)) - 16))
                                            : {20'($urandom), 1'b0},
                pick_reg());
    end else begin
      w = $urandom;
    end
    if (straight && (w[6:0] == OPC_BRANCH || w[6:0] == OPC_JAL)) w[6] = 1'b0;
    if (w == 32'h0) w = enc_i(OPC_OPIMM, 12'h000, 5'd0, F3_ADD, 5'd0);
    return w;
  endfunction

  // drivers
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_instruction_word <= $urandom;
    end
  endtask

  task automatic offer_word(input logic [31:0] w, input bit pinned, input retire_t res);
    if (!no_gaps && burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 20);
      idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3));
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_instruction_word <= w;
    word_pinned <= pinned;
    word_expect <= res;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    idle_cycles(1);
    while (pending_retires.size() != 0) idle_cycles(1);
    idle_cycles(4);
  endtask

  task automatic write_prog_len(input int v);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= PLEN_W'(v);
    prog_len = PLEN_W'(v);
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  function automatic void add_row(input row_kind_t k, input logic [31:0] v,
                                  input bit pinned = 1'b0, input retire_t res = '0);
    dir_row_t row;
    row.kind = k;
    row.value = v;
    row.pinned = pinned;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  // result side stall pattern, with one long hold-off on request
  initial begin
    int seg_left;
    int mode;
    seg_left = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_given) begin
        hold_given++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        seg_left = 0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(10, 120);
        end
        seg_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // scoreboard
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    retire_t want;
    retire_t model;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_retires.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = pending_retires.pop_front();
          check_field("stopped", 32'(want.stopped), 32'(out_stopped));
          check_field("next_pc", 32'(want.next_pc), 32'(out_next_pc));
          check_field("reg_write_enable", 32'(want.reg_we), 32'(out_reg_write_enable));
          check_field("reg_write_index", 32'(want.reg_idx), 32'(out_reg_write_index));
          check_field("reg_write_value", want.reg_val, out_reg_write_value);
          check_field("mem_write_enable", 32'(want.mem_we), 32'(out_mem_write_enable));
          check_field("mem_address", 32'(want.mem_addr), 32'(out_mem_address));
          check_field("mem_write_value", want.mem_val, out_mem_write_value);
          check_field("a0_value", want.a0, out_a0_value);
          check_field("a1_value", want.a1, out_a1_value);
        end
      end
      if (in_valid && !in_stall) begin
        model = retire_word(in_instruction_word);
        pending_retires.push_back(word_pinned ? word_expect : model);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int phase;
    int mode;
    int len;
    bit straight;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (data_words[i]) data_words[i] = '0;

    add_row(ROW_CFG, 32'd0);
    add_row(ROW_WORD, enc_j(21'd0, 5'd1), 1'b1,
            '{1'b0, 12'd0, 1'b1, 5'd1, 32'd4, 1'b0, 10'd0, 32'd0, 32'd0, 32'd0});
    add_row(ROW_WORD, enc_b(13'd0, 5'd0, 5'd0, F3_ADD), 1'b1, '0);
    add_row(ROW_CFG, 32'(IMEM_DEPTH));
    add_row(ROW_WORD, enc_u(20'hFFFFF, REG_A0), 1'b1,
            '{1'b0, 12'd1, 1'b1, 5'd10, 32'hFFFFF000, 1'b0, 10'd0, 32'd0,
              32'hFFFFF000, 32'd0});
    add_row(ROW_WORD, enc_i(OPC_OPIMM, 12'h800, 5'd0, F3_ADD, REG_A1), 1'b1,
            '{1'b0, 12'd2, 1'b1, 5'd11, 32'hFFFFF800, 1'b0, 10'd0, 32'd0,
              32'hFFFFF000, 32'hFFFFF800});
    add_row(ROW_WORD, enc_i(OPC_OPIMM, 12'h7FF, REG_A1, F3_ADD, REG_A1));
    add_row(ROW_WORD, enc_r(7'h20, REG_A1, REG_A0, F3_ADD, REG_A0));
    add_row(ROW_WORD, enc_r(7'h00, REG_A1, REG_A0, F3_XOR, 5'd12));
    add_row(ROW_WORD, enc_r(7'h00, REG_A0, REG_A1, F3_OR, 5'd13));
    add_row(ROW_WORD, enc_r(7'h20, 5'd12, REG_A0, F3_SRA, 5'd14));
    add_row(ROW_WORD, enc_r(7'h7F, REG_A1, REG_A0, 3'b011, 5'd15));
    add_row(ROW_WORD, enc_i(OPC_OPIMM, 12'hFFF, REG_A0, F3_XOR, 5'd16));
    add_row(ROW_WORD, enc_i(OPC_OPIMM, 12'h555, REG_A1, F3_OR, 5'd17));
    add_row(ROW_WORD, enc_i(OPC_OPIMM, 12'h41F, REG_A0, F3_SRA, REG_A0));
    add_row(ROW_WORD, enc_i(OPC_OPIMM, 12'hFFB, 5'd0, 3'b010, 5'd18));
    add_row(ROW_WORD, enc_s(12'hFFF, REG_A0, 5'd0, 3'b010));
    add_row(ROW_WORD, enc_s(12'h000, REG_A1, 5'd0, F3_BYTE));
    add_row(ROW_WORD, enc_i(OPC_LOAD, 12'hFFF, 5'd0, 3'b010, 5'd19));
    add_row(ROW_WORD, enc_i(OPC_LOAD, 12'h000, 5'd0, F3_BYTE, 5'd20));
    add_row(ROW_WORD, enc_i(OPC_LOAD, 12'hFFF, 5'd0, F3_BYTE, 5'd21));
    add_row(ROW_WORD, enc_i(OPC_LOAD, 12'h3E5, 5'd0, F3_SRA, 5'd22));
    add_row(ROW_WORD, enc_i(OPC_OPIMM, 12'd5, 5'd0, F3_ADD, 5'd0));
    add_row(ROW_WORD, enc_j(21'd8, 5'd0));
    add_row(ROW_WORD, enc_b(13'h1FFA, 5'd0, 5'd0, 3'b001));
    add_row(ROW_WORD, enc_b(13'd16, 5'd0, REG_A0, F3_ADD));
    add_row(ROW_WORD, 32'hFFFFFFFF);
    add_row(ROW_WORD, enc_j(21'h1FFE70, 5'd1));
    add_row(ROW_WORD, enc_j(21'h0FFFFE, 5'd0));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_prog_len(int'(dir_rows[i].value));
      end else begin
        offer_word(dir_rows[i].value, dir_rows[i].pinned, dir_rows[i].res);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      settle();
      mode = (phase == 2) ? 0 : $urandom_range(0, 3);
      straight = (mode >= 2);
      if (straight) begin
        len = $urandom_range(1, 120);
        write_prog_len((int'(fetch_pc) + len > IMEM_DEPTH) ? IMEM_DEPTH
                                                            : int'(fetch_pc) + len);
      end else begin
        len = $urandom_range(40, 160);
        write_prog_len((mode == 0) ? IMEM_DEPTH : IMEM_DEPTH - 1);
      end
      if (phase == 2) begin
        no_gaps = 1'b1;
        hold_asked++;
      end
      repeat (len) offer_word(make_word(straight), 1'b0, '0);
      no_gaps = 1'b0;
      sent += len;
      phase++;
    end

    // halt either on an all-zero word or by running past the program length
    settle();
    if ($urandom_range(0, 1) == 0 || fetch_pc == PC_W'(IMEM_DEPTH - 1)) begin
      offer_word(32'h0, 1'b0, '0);
    end else begin
      write_prog_len(int'(fetch_pc));
      offer_word(make_word(1'b1), 1'b0, '0);
    end
    repeat (30) offer_word(($urandom_range(0, 3) == 0) ? 32'h0 : make_word(1'b0), 1'b0, '0);

    idle_cycles(1);
    while (pending_retires.size() != 0) idle_cycles(1);
    idle_cycles(8);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/rvsc_pkg.sv
sv/rvsc_ram.sv
sv/rvsc_exec.sv
sv/rv32_subset_single_cycle_core.sv
dv/rv32_subset_single_cycle_core_tb.sv
